FILE: hdl/calendar_clock_with_tick_prescaler_top_assert.svh
// assertion macros for the calendar clock block
`ifndef CALENDAR_CLOCK_WITH_TICK_PRESCALER_TOP_ASSERT_SVH
`define CALENDAR_CLOCK_WITH_TICK_PRESCALER_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define CAL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("calendar clock check failed");

// next-cycle implication, checked out of reset
`define CAL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("calendar clock check failed");

`endif

FILE: hdl/cal_pkg.sv
// shared types, constants and calendar functions for the calendar clock
package cal_pkg;

  localparam int unsigned CFG_W = 16;
  localparam int unsigned OUT_W = 112;

  localparam logic [15:0] TPS_RESET         = 16'd1000;
  localparam logic [13:0] START_YEAR_RESET  = 14'd2022;
  localparam logic [3:0]  START_MONTH_RESET = 4'd1;
  localparam logic [4:0]  START_DAY_RESET   = 5'd1;
  localparam logic [2:0]  WEEKDAY_RESET     = 3'd6;
  localparam logic [6:0]  YR_MOD100_RESET   = 7'd22;
  localparam logic [1:0]  CENT_MOD4_RESET   = 2'd0;
  localparam logic [13:0] YEAR_MAX          = 14'd9999;

  typedef enum logic [1:0] {
    REG_TPS   = 2'd0,
    REG_YEAR  = 2'd1,
    REG_MONTH = 2'd2,
    REG_DAY   = 2'd3
  } cfg_reg_e;

  // result of a date reload, handed from the loader to the counters
  typedef struct packed {
    logic        busy;
    logic        commit;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [2:0]  weekday;
    logic [6:0]  yr_mod100;
    logic [1:0]  cent_mod4;
  } date_load_t;

  function automatic logic is_leap(input logic [1:0] yr_mod4, input logic [6:0] yr_mod100,
                                   input logic [1:0] cent_mod4);
    logic leap;
    leap = (yr_mod4 == 2'd0) && ((yr_mod100 != 7'd0) || (cent_mod4 == 2'd0));
    return leap;
  endfunction

  function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
    logic [4:0] n;
    case (month)
      4'd2:    n = leap ? 5'd29 : 5'd28;
      4'd4:    n = 5'd30;
      4'd6:    n = 5'd30;
      4'd9:    n = 5'd30;
      4'd11:   n = 5'd30;
      default: n = 5'd31;
    endcase
    return n;
  endfunction

  // 13 * (m + 1) / 5 with january and february counted as months 13 and 14
  function automatic logic [5:0] zeller_term(input logic [3:0] month);
    logic [5:0] t;
    case (month)
      4'd1:    t = 6'd36;
      4'd2:    t = 6'd39;
      4'd3:    t = 6'd10;
      4'd4:    t = 6'd13;
      4'd5:    t = 6'd15;
      4'd6:    t = 6'd18;
      4'd7:    t = 6'd20;
      4'd8:    t = 6'd23;
      4'd9:    t = 6'd26;
      4'd10:   t = 6'd28;
      4'd11:   t = 6'd31;
      4'd12:   t = 6'd33;
      default: t = 6'd36;
    endcase
    return t;
  endfunction

endpackage

FILE: hdl/cal_date_load.sv
// start date registers and the pipeline that clamps a new date and finds its weekday
module cal_date_load (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_idx_i,
  input  logic [cal_pkg::CFG_W-1:0] cfg_data_i,
  output cal_pkg::date_load_t       load_o
);
  import cal_pkg::*;

  logic [13:0] start_year_q;
  logic [3:0]  start_month_q;
  logic [4:0]  start_day_q;
  logic [2:0]  stage_q, stage_d;
  logic        date_wr;

  logic [13:0] s1_year_q, s1_year_d;
  logic [3:0]  s1_month_q, s1_month_d;
  logic [6:0]  s2_c_q, s2_yy_q;
  logic [26:0] s2_prod;
  logic [6:0]  s2_c_d;
  logic [13:0] s2_rem;
  logic [4:0]  s3_day_q, s3_day_d;
  logic [6:0]  s3_cz_q, s3_cz_d, s3_yz_q, s3_yz_d;
  logic [5:0]  s3_t_q;
  logic        s3_leap;
  logic [4:0]  s3_len;
  logic [8:0]  s4_w_q;
  logic [9:0]  s4_w_d;
  logic [17:0] s5_prod;
  logic [8:0]  s5_rem;
  logic [3:0]  s5_r;
  logic [2:0]  s5_wd;

  assign date_wr = cfg_we_i && ((cfg_idx_i == REG_YEAR) || (cfg_idx_i == REG_MONTH) ||
                                (cfg_idx_i == REG_DAY));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_year_q  <= START_YEAR_RESET;
      start_month_q <= START_MONTH_RESET;
      start_day_q   <= START_DAY_RESET;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_YEAR:  start_year_q  <= cfg_data_i[13:0];
        REG_MONTH: start_month_q <= cfg_data_i[3:0];
        REG_DAY:   start_day_q   <= cfg_data_i[4:0];
        default:   ;
      endcase
    end
  end

  // a date write restarts the pipeline, step 5 hands the result over
  always_comb begin
    if (date_wr) begin
      stage_d = 3'd1;
    end else if (stage_q == 3'd5) begin
      stage_d = 3'd0;
    end else if (stage_q != 3'd0) begin
      stage_d = stage_q + 3'd1;
    end else begin
      stage_d = 3'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= 3'd0;
    end else begin
      stage_q <= stage_d;
    end
  end

  // step 1: clamp year and month
  always_comb begin
    s1_year_d = start_year_q;
    if (start_year_q == 14'd0) s1_year_d = 14'd1;
    if (start_year_q > YEAR_MAX) s1_year_d = YEAR_MAX;
    s1_month_d = start_month_q;
    if (start_month_q == 4'd0) s1_month_d = 4'd1;
    if (start_month_q > 4'd12) s1_month_d = 4'd12;
  end

  // step 2: century and year of century, divide by 100 through a reciprocal
  assign s2_prod = 27'(s1_year_q) * 27'd5243;
  assign s2_c_d  = s2_prod[25:19];
  assign s2_rem  = s1_year_q - 14'(s2_c_d) * 14'd100;

  // step 3: leap year, day clamp, zeller year shift for january and february
  assign s3_leap = is_leap(s1_year_q[1:0], s2_yy_q, s2_c_q[1:0]);
  assign s3_len  = month_days(s1_month_q, s3_leap);

  always_comb begin
    s3_day_d = start_day_q;
    if (start_day_q == 5'd0) s3_day_d = 5'd1;
    if (start_day_q > s3_len) s3_day_d = s3_len;
    s3_cz_d = s2_c_q;
    s3_yz_d = s2_yy_q;
    if (s1_month_q <= 4'd2) begin
      if (s2_yy_q == 7'd0) begin
        s3_yz_d = 7'd99;
        s3_cz_d = s2_c_q - 7'd1;
      end else begin
        s3_yz_d = s2_yy_q - 7'd1;
      end
    end
  end

  // step 4: zeller sum less one, offset by a multiple of seven to stay positive
  assign s4_w_d = 10'd181 + 10'(s3_cz_q >> 2) + 10'(s3_yz_q) + 10'(s3_yz_q >> 2) +
                  10'(s3_t_q) + 10'(s3_day_q) - 10'({s3_cz_q, 1'b0});

  // step 5: sum mod 7, reciprocal estimate is exact or one low
  assign s5_prod = 18'(s4_w_q) * 18'd292;
  assign s5_rem  = s4_w_q - 9'(s5_prod[17:11]) * 9'd7;
  assign s5_r    = (s5_rem[3:0] >= 4'd7) ? (s5_rem[3:0] - 4'd7) : s5_rem[3:0];
  assign s5_wd   = s5_r[2:0];

  always_ff @(posedge clk_i) begin
    if (stage_q == 3'd1) begin
      s1_year_q  <= s1_year_d;
      s1_month_q <= s1_month_d;
    end
    if (stage_q == 3'd2) begin
      s2_c_q  <= s2_c_d;
      s2_yy_q <= s2_rem[6:0];
    end
    if (stage_q == 3'd3) begin
      s3_day_q <= s3_day_d;
      s3_cz_q  <= s3_cz_d;
      s3_yz_q  <= s3_yz_d;
      s3_t_q   <= zeller_term(s1_month_q);
    end
    if (stage_q == 3'd4) begin
      s4_w_q <= s4_w_d[8:0];
    end
  end

  always_comb begin
    load_o.busy      = (stage_q != 3'd0);
    load_o.commit    = (stage_q == 3'd5);
    load_o.year      = s1_year_q;
    load_o.month     = s1_month_q;
    load_o.day       = s3_day_q;
    load_o.weekday   = s5_wd;
    load_o.yr_mod100 = s2_yy_q;
    load_o.cent_mod4 = s2_c_q[1:0];
  end

endmodule

FILE: hdl/calendar_clock_with_tick_prescaler_top.sv
// top level of the calendar clock with millisecond tick prescaler
// usage:
//   input stream: one transaction per cycle at most, tdata bit 0 is the tick;
//   a tick advances the uptime and the prescaler, and every ticks_per_second
//   ticks one calendar second passes (time, weekday, day, month, year).
//   output stream: one transaction per input transaction carrying the state
//   after that tick, registered, so it shows in the cycle after acceptance.
//   throughput is one tick per cycle while no date load or stall holds it off;
//   the next input is taken in the same cycle that the waiting result is taken.
//   when the receiver stalls the result holds and s_axis_tready drops until
//   the output register is free.
//   config: a write to start_year, start_month or start_day reloads the date
//   and clears the time of day and the seconds stamp; the input is held off
//   while the load pipeline clamps the date and finds its weekday. a write to
//   ticks_per_second takes effect at once.
//   reset: 1 January 2022, a Saturday, 00:00:00, uptime zero, rate 1000.
`include "calendar_clock_with_tick_prescaler_top_assert.svh"

module calendar_clock_with_tick_prescaler_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,  // tick
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // uptime_ms, seconds_count, second_strobe, second_now, minute_now, hour_now,
  // day_now, month_now, year_now, weekday_now
  output logic [cal_pkg::OUT_W-1:0]   m_axis_tdata,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_idx_i,
  input  logic [cal_pkg::CFG_W-1:0]   cfg_data_i
);
  import cal_pkg::*;

  date_load_t  load;
  logic        accept;
  logic        tick;

  logic [15:0] tps_q;
  logic [15:0] presc_q, presc_d;
  logic [31:0] uptime_q, uptime_d;
  logic [31:0] elapsed_q, elapsed_d;
  logic [5:0]  sec_q, sec_d;
  logic [5:0]  min_q, min_d;
  logic [4:0]  hour_q, hour_d;
  logic [4:0]  day_q, day_d;
  logic [3:0]  month_q, month_d;
  logic [13:0] year_q, year_d;
  logic [2:0]  wday_q, wday_d;
  logic [6:0]  mod100_q, mod100_d;
  logic [1:0]  cent4_q, cent4_d;
  logic        strobe_d;

  logic [16:0] presc_inc;
  logic        leap_now;
  logic [4:0]  day_len;

  logic                 out_valid_q;
  logic [OUT_W-1:0]     out_data_q;

  cal_date_load u_date_load (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .load_o     (load)
  );

  assign s_axis_tready = !load.busy && (!out_valid_q || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign tick          = s_axis_tdata[0];

  assign presc_inc = {1'b0, presc_q} + 17'd1;
  assign leap_now  = is_leap(year_q[1:0], mod100_q, cent4_q);
  assign day_len   = month_days(month_q, leap_now);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q <= TPS_RESET;
    end else if (cfg_we_i && (cfg_idx_i == REG_TPS)) begin
      tps_q <= cfg_data_i;
    end
  end

  always_comb begin
    presc_d   = presc_q;
    uptime_d  = uptime_q;
    elapsed_d = elapsed_q;
    sec_d     = sec_q;
    min_d     = min_q;
    hour_d    = hour_q;
    day_d     = day_q;
    month_d   = month_q;
    year_d    = year_q;
    wday_d    = wday_q;
    mod100_d  = mod100_q;
    cent4_d   = cent4_q;
    strobe_d  = 1'b0;
    if (load.commit) begin
      presc_d   = '0;
      elapsed_d = '0;
      sec_d     = '0;
      min_d     = '0;
      hour_d    = '0;
      day_d     = load.day;
      month_d   = load.month;
      year_d    = load.year;
      wday_d    = load.weekday;
      mod100_d  = load.yr_mod100;
      cent4_d   = load.cent_mod4;
    end else if (accept && tick) begin
      uptime_d = uptime_q + 32'd1;
      presc_d  = presc_inc[15:0];
      if (presc_inc >= {1'b0, tps_q}) begin
        presc_d   = '0;
        strobe_d  = 1'b1;
        elapsed_d = elapsed_q + 32'd1;
        // carry ripples from seconds up to the year
        if (sec_q < 6'd59) begin
          sec_d = sec_q + 6'd1;
        end else begin
          sec_d = '0;
          if (min_q < 6'd59) begin
            min_d = min_q + 6'd1;
          end else begin
            min_d = '0;
            if (hour_q < 5'd23) begin
              hour_d = hour_q + 5'd1;
            end else begin
              hour_d = '0;
              wday_d = (wday_q >= 3'd6) ? 3'd0 : wday_q + 3'd1;
              if (day_q < day_len) begin
                day_d = day_q + 5'd1;
              end else begin
                day_d = 5'd1;
                if (month_q < 4'd12) begin
                  month_d = month_q + 4'd1;
                end else begin
                  month_d = 4'd1;
                  if (year_q < YEAR_MAX) begin
                    year_d = year_q + 14'd1;
                    if (mod100_q == 7'd99) begin
                      mod100_d = '0;
                      cent4_d  = cent4_q + 2'd1;
                    end else begin
                      mod100_d = mod100_q + 7'd1;
                    end
                  end
                end
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      presc_q   <= '0;
      uptime_q  <= '0;
      elapsed_q <= '0;
      sec_q     <= '0;
      min_q     <= '0;
      hour_q    <= '0;
      day_q     <= START_DAY_RESET;
      month_q   <= START_MONTH_RESET;
      year_q    <= START_YEAR_RESET;
      wday_q    <= WEEKDAY_RESET;
      mod100_q  <= YR_MOD100_RESET;
      cent4_q   <= CENT_MOD4_RESET;
    end else begin
      presc_q   <= presc_d;
      uptime_q  <= uptime_d;
      elapsed_q <= elapsed_d;
      sec_q     <= sec_d;
      min_q     <= min_d;
      hour_q    <= hour_d;
      day_q     <= day_d;
      month_q   <= month_d;
      year_q    <= year_d;
      wday_q    <= wday_d;
      mod100_q  <= mod100_d;
      cent4_q   <= cent4_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= {4'd0, wday_d, year_d, month_d, day_d, hour_d, min_d, sec_d,
                     strobe_d, elapsed_d, uptime_d};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  `CAL_ASSERT_NOW(a_no_accept_during_load, load.busy, !s_axis_tready)
  `CAL_ASSERT_NOW(a_time_of_day_range, 1'b1, (sec_q <= 6'd59) && (min_q <= 6'd59) && (hour_q <= 5'd23))
  `CAL_ASSERT_NOW(a_day_in_month, 1'b1, (day_q >= 5'd1) && (day_q <= day_len))
  `CAL_ASSERT_NEXT(a_strobe_counts_second, accept && strobe_d, elapsed_q == $past(elapsed_q) + 32'd1)

endmodule

FILE: verif/tb.sv
// testbench for the calendar clock with millisecond tick prescaler
module tb;
  import cal_pkg::*;

  typedef struct packed {
    logic [2:0]  weekday;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic        strobe;
    logic [31:0] secs;
    logic [31:0] uptime;
  } clock_reading_t;

  localparam int READING_W = $bits(clock_reading_t);
  localparam int BURST_TICKS = 130;
  localparam int MAX_SHOWN = 200;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [7:0]       s_axis_tdata = 8'd0;   // tick
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  // uptime_ms, seconds_count, second_strobe, second_now, minute_now, hour_now,
  // day_now, month_now, year_now, weekday_now
  logic [OUT_W-1:0] m_axis_tdata;
  logic             cfg_we_i = 1'b0;
  logic [1:0]       cfg_idx_i = 2'd0;
  logic [CFG_W-1:0] cfg_data_i = '0;

  calendar_clock_with_tick_prescaler_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // calendar shadow state
  logic [15:0] cal_tps;
  logic [13:0] cal_start_year;
  logic [3:0]  cal_start_month;
  logic [4:0]  cal_start_day;
  logic [16:0] cal_presc;
  logic [31:0] cal_uptime;
  logic [31:0] cal_secs;
  logic [5:0]  cal_sec;
  logic [5:0]  cal_min;
  logic [4:0]  cal_hour;
  logic [4:0]  cal_day;
  logic [3:0]  cal_month;
  logic [13:0] cal_year;
  logic [2:0]  cal_wday;

  clock_reading_t pending_readings[$];
  clock_reading_t want_r;
  clock_reading_t got_r;

  bit idle_on = 1'b1;
  int errors = 0;
  int ticks_sent = 0;
  int readings_checked = 0;
  int strobes_seen = 0;
  int reg_writes = 0;

  function automatic int days_of(input int y, input int m);
    int n;
    bit leap;
    leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    case (m)
      2:       n = leap ? 29 : 28;
      4, 6, 9, 11: n = 30;
      default: n = 31;
    endcase
    return n;
  endfunction

  // zeller's congruence, 0 is sunday
  function automatic logic [2:0] weekday_of(input int y, input int m, input int d);
    int c;
    int yy;
    int w;
    if (m <= 2) begin
      y = y - 1;
      m = m + 12;
    end
    c = y / 100;
    yy = y % 100;
    w = c / 4 - 2 * c + yy + yy / 4 + (13 * (m + 1)) / 5 + d - 1;
    w = w % 7;
    if (w < 0) w = w + 7;
    return w[2:0];
  endfunction

  task automatic reload_date();
    int y;
    int m;
    int d;
    int len;
    y = int'(cal_start_year);
    m = int'(cal_start_month);
    d = int'(cal_start_day);
    if (y < 1) y = 1;
    if (y > 9999) y = 9999;
    if (m < 1) m = 1;
    if (m > 12) m = 12;
    len = days_of(y, m);
    if (d < 1) d = 1;
    if (d > len) d = len;
    cal_year = y[13:0];
    cal_month = m[3:0];
    cal_day = d[4:0];
    cal_wday = weekday_of(y, m, d);
    cal_presc = '0;
    cal_sec = '0;
    cal_min = '0;
    cal_hour = '0;
    cal_secs = '0;
  endtask

  task automatic clock_reset();
    cal_tps = 16'd1000;
    cal_start_year = 14'd2022;
    cal_start_month = 4'd1;
    cal_start_day = 5'd1;
    cal_uptime = '0;
    reload_date();
  endtask

  task automatic advance_second();
    cal_secs = cal_secs + 32'd1;
    if (cal_sec < 6'd59) begin
      cal_sec = cal_sec + 6'd1;
    end else begin
      cal_sec = '0;
      if (cal_min < 6'd59) begin
        cal_min = cal_min + 6'd1;
      end else begin
        cal_min = '0;
        if (cal_hour < 5'd23) begin
          cal_hour = cal_hour + 5'd1;
        end else begin
          cal_hour = '0;
          cal_wday = (cal_wday >= 3'd6) ? 3'd0 : cal_wday + 3'd1;
          if (int'(cal_day) < days_of(int'(cal_year), int'(cal_month))) begin
            cal_day = cal_day + 5'd1;
          end else begin
            cal_day = 5'd1;
            if (cal_month < 4'd12) begin
              cal_month = cal_month + 4'd1;
            end else begin
              cal_month = 4'd1;
              if (cal_year < 14'd9999) cal_year = cal_year + 14'd1;
            end
          end
        end
      end
    end
  endtask

  // one accepted transaction: advance the shadow clock and queue its reading
  task automatic clock_step(input bit tick);
    clock_reading_t r;
    r.strobe = 1'b0;
    if (tick) begin
      cal_uptime = cal_uptime + 32'd1;
      cal_presc = cal_presc + 17'd1;
      if (cal_presc >= {1'b0, cal_tps}) begin
        cal_presc = '0;
        r.strobe = 1'b1;
        advance_second();
      end
    end
    r.uptime = cal_uptime;
    r.secs = cal_secs;
    r.second = cal_sec;
    r.minute = cal_min;
    r.hour = cal_hour;
    r.day = cal_day;
    r.month = cal_month;
    r.year = cal_year;
    r.weekday = cal_wday;
    pending_readings.push_back(r);
  endtask

  task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= MAX_SHOWN)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_r = clock_reading_t'(m_axis_tdata[READING_W-1:0]);
      if (pending_readings.size() == 0) begin
        errors++;
        if (errors <= MAX_SHOWN)
          $display("%0t: unexpected result, expected none, got uptime %0d", $time,
                   got_r.uptime);
      end else begin
        want_r = pending_readings.pop_front();
        readings_checked++;
        if (want_r.strobe) strobes_seen++;
        check_field("uptime_ms", want_r.uptime, got_r.uptime);
        check_field("seconds_count", want_r.secs, got_r.secs);
        check_field("second_strobe", 32'(want_r.strobe), 32'(got_r.strobe));
        check_field("second_now", 32'(want_r.second), 32'(got_r.second));
        check_field("minute_now", 32'(want_r.minute), 32'(got_r.minute));
        check_field("hour_now", 32'(want_r.hour), 32'(got_r.hour));
        check_field("day_now", 32'(want_r.day), 32'(got_r.day));
        check_field("month_now", 32'(want_r.month), 32'(got_r.month));
        check_field("year_now", 32'(want_r.year), 32'(got_r.year));
        check_field("weekday_now", 32'(want_r.weekday), 32'(got_r.weekday));
        check_field("tdata padding", 32'd0, 32'(m_axis_tdata[OUT_W-1:READING_W]));
      end
    end
  end

  // receiver with random stall bursts
  initial begin
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (idle_on && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  task automatic send_tick(input bit tick);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'd0, tick};
    do @(posedge clk_i); while (!s_axis_tready);
    ticks_sent++;
    clock_step(tick);
  endtask

  // stop sending and wait for every queued reading to come back
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e sel, input logic [15:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= sel;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    reg_writes++;
    case (sel)
      REG_TPS:   cal_tps = value;
      REG_YEAR:  begin cal_start_year = value[13:0]; reload_date(); end
      REG_MONTH: begin cal_start_month = value[3:0]; reload_date(); end
      REG_DAY:   begin cal_start_day = value[4:0]; reload_date(); end
      default: ;
    endcase
    // let the date load pipeline finish
    repeat (8) @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_value(input cfg_reg_e sel);
    int r;
    logic [15:0] v;
    r = $urandom_range(0, 9);
    v = 16'($urandom);
    case (sel)
      REG_TPS: begin
        if (r < 5) v = 16'($urandom_range(0, 3));
        else if (r < 8) v = 16'($urandom_range(4, 40));
      end
      REG_YEAR: begin
        if (r < 6) v = 16'($urandom_range(1, 9999));
        else if (r < 7) v = 16'd0;
        else if (r < 9) v = 16'($urandom_range(9999, 16383));
      end
      REG_MONTH: begin
        if (r < 7) v = 16'($urandom_range(1, 12));
        else if (r < 9) v = 16'($urandom_range(0, 15));
      end
      default: begin
        if (r < 8) v = 16'($urandom_range(0, 31));
      end
    endcase
    return v;
  endfunction

  task automatic test_reset_values();
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b1);
    settle();
  endtask

  task automatic test_zero_rate();
    write_reg(REG_TPS, 16'd0);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    settle();
    write_reg(REG_TPS, 16'd1);
    send_tick(1'b1);
    send_tick(1'b1);
    settle();
  endtask

  // lowering the rate below the prescaler makes the next tick a second
  task automatic test_rate_change();
    write_reg(REG_TPS, 16'hFFFF);
    repeat (5) send_tick(1'b1);
    settle();
    write_reg(REG_TPS, 16'd3);
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b1);
    settle();
  endtask

  task automatic test_date_clamp();
    write_reg(REG_YEAR, 16'd0);
    send_tick(1'b1);
    settle();
    write_reg(REG_YEAR, 16'hFFFF);
    send_tick(1'b0);
    settle();
    write_reg(REG_MONTH, 16'd0);
    send_tick(1'b0);
    settle();
    write_reg(REG_MONTH, 16'hFFFF);
    send_tick(1'b0);
    settle();
    write_reg(REG_YEAR, 16'd2024);
    write_reg(REG_MONTH, 16'd2);
    write_reg(REG_DAY, 16'd31);
    send_tick(1'b1);
    settle();
    write_reg(REG_YEAR, 16'd2023);
    send_tick(1'b0);
    settle();
    write_reg(REG_DAY, 16'hFFE0);
    send_tick(1'b1);
    settle();
  endtask

  task automatic test_random_traffic();
    int phase;
    int n;
    cfg_reg_e sel;
    for (phase = 0; phase < 11; phase++) begin
      settle();
      sel = (phase == 0) ? REG_TPS : cfg_reg_e'($urandom_range(0, 3));
      write_reg(sel, pick_value(sel));
      if ($urandom_range(0, 2) == 0) begin
        sel = cfg_reg_e'($urandom_range(0, 3));
        write_reg(sel, pick_value(sel));
      end
      for (n = 0; n < 150; n++) send_tick($urandom_range(0, 7) != 0);
    end
    settle();
  endtask

  // gap-free ticks at one second each, carrying seconds into minutes
  task automatic test_back_to_back();
    idle_on = 1'b0;
    settle();
    write_reg(REG_TPS, 16'd0);
    write_reg(REG_DAY, 16'd1);
    repeat (BURST_TICKS) send_tick(1'b1);
    settle();
  endtask

  initial begin
    clock_reset();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_values();
    test_zero_rate();
    test_rate_change();
    test_date_clamp();
    test_random_traffic();
    test_back_to_back();
    settle();
    repeat (20) @(posedge clk_i);
    if (pending_readings.size() != 0) begin
      errors++;
      $display("%0t: readings left over, expected 0, got %0d", $time, pending_readings.size());
    end
    $display("run: %0d tick transactions, %0d readings checked, %0d second strobes",
             ticks_sent, readings_checked, strobes_seen);
    $display("run: %0d register writes, stalls on both sides, then %0d gap-free ticks",
             reg_writes, BURST_TICKS);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("timeout with %0d readings pending", pending_readings.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
